// ===== src/key_click_event_detector_assert.svh =====
`ifndef KEY_CLICK_EVENT_DETECTOR_ASSERT_SVH
`define KEY_CLICK_EVENT_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define KCED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clk edge outside reset.
`define KCED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kced_pkg.sv =====
package kced_pkg;

	// Fixed field widths
	localparam int PRESS_W = 2;
	localparam int REG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// Per-key phase, one-hot
	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_PRESS1 = 8'b0000_0010,
		PH_GAP1   = 8'b0000_0100,
		PH_PRESS2 = 8'b0000_1000,
		PH_GAP2   = 8'b0001_0000,
		PH_PRESS3 = 8'b0010_0000,
		PH_TRIPLE = 8'b0100_0000,
		PH_EXCEPT = 8'b1000_0000
	} phase_t;

	// Event codes
	typedef enum logic [2:0] {
		EV_S_PRES   = 3'd0,
		EV_S_REL    = 3'd1,
		EV_D_CLICK  = 3'd2,
		EV_T_CLICK  = 3'd3,
		EV_L_PRES   = 3'd4,
		EV_L_REPEAT = 3'd5,
		EV_L_REL    = 3'd6,
		EV_NONE     = 3'd7
	} ev_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_LONG_PRESS  = 3'd1,
		REG_SHORT_MIN   = 3'd2,
		REG_SHORT_MAX   = 3'd3,
		REG_FIRST_GAP   = 3'd4,
		REG_SECOND_GAP  = 3'd5,
		REG_SECOND_HOLD = 3'd6,
		REG_THIRD_HOLD  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic             multi_click_mode;
		logic [REG_W-1:0] long_press_ticks;
		logic [REG_W-1:0] short_min_ticks;
		logic [REG_W-1:0] short_max_ticks;
		logic [REG_W-1:0] first_gap_ticks;
		logic [REG_W-1:0] second_gap_ticks;
		logic [REG_W-1:0] second_hold_max_ticks;
		logic [REG_W-1:0] third_hold_max_ticks;
	} cfg_t;

endpackage

// ===== src/kced_lane.sv =====
module kced_lane
	import kced_pkg::*;
#(
	parameter int TICK_W = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic down,
	input  cfg_t cfg,
	output ev_t  ev
);

	`include "key_click_event_detector_assert.svh"

	localparam int CMP_W = (TICK_W > REG_W) ? TICK_W : REG_W;

	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] ticks_q, ticks_d, ticks_inc;
	ev_t               prev_q;
	logic [CMP_W-1:0]  cur_x, inc_x;

	// Saturating tick increment
	assign ticks_inc = (ticks_q == {TICK_W{1'b1}}) ? ticks_q : ticks_q + TICK_W'(1);
	assign cur_x     = CMP_W'(ticks_q);
	assign inc_x     = CMP_W'(ticks_inc);

	// Next phase, counter and event for this tick
	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		ev      = prev_q;
		unique case (phase_q) inside
			PH_IDLE: begin
				ev = EV_NONE;
				if (down) begin
					phase_d = PH_PRESS1;
					ticks_d = '0;
				end
			end
			PH_PRESS1: begin
				if (down) begin
					ticks_d = ticks_inc;
					if (ticks_inc == TICK_W'(1)) begin
						ev = EV_S_PRES;
					end else if (inc_x >= CMP_W'(cfg.long_press_ticks)) begin
						ev = (prev_q == EV_L_PRES || prev_q == EV_L_REPEAT) ?
							EV_L_REPEAT : EV_L_PRES;
					end else begin
						ev = EV_NONE;
					end
				end else if (!cfg.multi_click_mode) begin
					if (cur_x >= CMP_W'(cfg.short_min_ticks) &&
					    cur_x < CMP_W'(cfg.short_max_ticks)) begin
						ev = EV_S_REL;
					end else if (cur_x >= CMP_W'(cfg.long_press_ticks)) begin
						ev = EV_L_REL;
					end else begin
						ev = EV_NONE;
					end
					phase_d = PH_IDLE;
					ticks_d = '0;
				end else if (cur_x >= CMP_W'(cfg.long_press_ticks)) begin
					ev      = EV_L_REL;
					phase_d = PH_IDLE;
					ticks_d = '0;
				end else begin
					ev      = EV_NONE;
					phase_d = PH_GAP1;
					ticks_d = '0;
				end
			end
			PH_GAP1, PH_GAP2: begin
				if (down) begin
					phase_d = (phase_q == PH_GAP1) ? PH_PRESS2 : PH_PRESS3;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
					if (phase_q == PH_GAP1) begin
						if (inc_x > CMP_W'(cfg.first_gap_ticks)) begin
							ev      = EV_S_REL;
							phase_d = PH_IDLE;
							ticks_d = '0;
						end
					end else if (inc_x > CMP_W'(cfg.second_gap_ticks)) begin
						ev      = EV_D_CLICK;
						phase_d = PH_IDLE;
						ticks_d = '0;
					end
				end
			end
			PH_PRESS2, PH_PRESS3: begin
				if (down) begin
					ticks_d = ticks_inc;
					if (inc_x > ((phase_q == PH_PRESS2) ?
					             CMP_W'(cfg.second_hold_max_ticks) :
					             CMP_W'(cfg.third_hold_max_ticks))) begin
						phase_d = PH_EXCEPT;
						ticks_d = '0;
					end
				end else begin
					phase_d = (phase_q == PH_PRESS2) ? PH_GAP2 : PH_TRIPLE;
					ticks_d = '0;
				end
			end
			PH_TRIPLE: begin
				ev      = EV_T_CLICK;
				phase_d = PH_IDLE;
				ticks_d = '0;
			end
			PH_EXCEPT: begin
				ev = EV_NONE;
				if (!down) begin
					phase_d = PH_IDLE;
					ticks_d = '0;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Advance the key state once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			prev_q  <= EV_NONE;
		end else if (advance) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			prev_q  <= ev;
		end
	end

	`KCED_ASSERT_NEXT(a_phase_change_clears_ticks, advance && (phase_d != phase_q),
		ticks_q == '0, "tick counter not cleared on phase change")

endmodule

// ===== src/kced_merge.sv =====
module kced_merge
	import kced_pkg::*;
#(
	parameter int NUM_KEYS = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  ev_t        lane_ev [NUM_KEYS],
	output logic       busy,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       key_id,
	output logic [2:0] event_code,
	output logic       last_event
);

	`include "key_click_event_detector_assert.svh"

	logic [NUM_KEYS-1:0] pend_s1;
	ev_t                 code_s1 [NUM_KEYS];
	logic [NUM_KEYS-1:0] sel_oh;
	logic                sel_key;
	ev_t                 sel_code;
	logic                any_pend, rest_any, out_ready, take;
	logic                out_valid_q, key_q, last_q;
	ev_t                 code_q;

	// Pick the lowest pending key
	always_comb begin
		sel_oh   = '0;
		sel_key  = 1'b0;
		sel_code = EV_NONE;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (pend_s1[k]) begin
				sel_oh    = '0;
				sel_oh[k] = 1'b1;
				sel_key   = 1'(k);
				sel_code  = code_s1[k];
			end
		end
	end

	assign any_pend  = |pend_s1;
	assign rest_any  = |(pend_s1 & ~sel_oh);
	assign out_ready = !out_valid_q || !out_stall;
	assign take      = out_ready && any_pend;
	// Hold off new ticks until the last pending event moves out
	assign busy      = any_pend && !(take && !rest_any);

	// Load the events of a tick, drop each one as it moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (load) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				pend_s1[k] <= (lane_ev[k] != EV_NONE);
			end
		end else if (take) begin
			pend_s1 <= pend_s1 & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				code_s1[k] <= lane_ev[k];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= any_pend;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q  <= sel_key;
			code_q <= sel_code;
			last_q <= !rest_any;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_id     = key_q;
	assign event_code = code_q;
	assign last_event = last_q;

	`KCED_ASSERT_NOW(a_no_empty_event, out_valid_q, code_q != EV_NONE,
		"output transaction carries no event")
	`KCED_ASSERT_NEXT(a_tick_continues, out_valid_q && !out_stall && !last_q,
		out_valid_q, "events of one tick not delivered back to back")
	`KCED_ASSERT_NEXT(a_drain_empties, take && !rest_any && !load,
		pend_s1 == '0, "pending events left after the last one was taken")

endmodule

// ===== src/key_click_event_detector.sv =====
// Order: an accepted scan tick is loaded into the pending event registers; its events
//   then go to the output register in key order, one per cycle unless stalled.
// Throughput: one tick per cycle while at most one key reports and nothing stalls; a
//   tick with more events holds the input until all move out, one output slot each.
// Reset (arst_n low): every key idle with counters at zero, registers at their defaults.
module key_click_event_detector
	import kced_pkg::*;
#(
	parameter int NUM_KEYS         = 2,
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PRESS_W-1:0]   pressed_mask,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 key_id,
	output logic [2:0]           event_code,
	output logic                 last_event,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	logic accept, busy;
	ev_t  lane_ev [NUM_KEYS];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.multi_click_mode      <= 1'b0;
			cfg_q.long_press_ticks      <= REG_W'(100);
			cfg_q.short_min_ticks       <= REG_W'(2);
			cfg_q.short_max_ticks       <= REG_W'(100);
			cfg_q.first_gap_ticks       <= REG_W'(30);
			cfg_q.second_gap_ticks      <= REG_W'(30);
			cfg_q.second_hold_max_ticks <= REG_W'(30);
			cfg_q.third_hold_max_ticks  <= REG_W'(30);
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_MODE:        cfg_q.multi_click_mode      <= cfg_data[0];
				REG_LONG_PRESS:  cfg_q.long_press_ticks      <= cfg_data;
				REG_SHORT_MIN:   cfg_q.short_min_ticks       <= cfg_data;
				REG_SHORT_MAX:   cfg_q.short_max_ticks       <= cfg_data;
				REG_FIRST_GAP:   cfg_q.first_gap_ticks       <= cfg_data;
				REG_SECOND_GAP:  cfg_q.second_gap_ticks      <= cfg_data;
				REG_SECOND_HOLD: cfg_q.second_hold_max_ticks <= cfg_data;
				REG_THIRD_HOLD:  cfg_q.third_hold_max_ticks  <= cfg_data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	// One lane per key; keys beyond the mask width read as released
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic down;
		if (k < PRESS_W) begin : g_bit
			assign down = pressed_mask[k];
		end else begin : g_none
			assign down = 1'b0;
		end
		kced_lane #(
			.TICK_W(TICK_COUNT_WIDTH)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.advance(accept),
			.down(down),
			.cfg(cfg_q),
			.ev(lane_ev[k])
		);
	end

	// Serialize the lane events
	kced_merge #(
		.NUM_KEYS(NUM_KEYS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.lane_ev(lane_ev),
		.busy(busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_id(key_id),
		.event_code(event_code),
		.last_event(last_event)
	);

endmodule

// ===== bench/key_click_event_detector_test.sv =====
`timescale 1ns / 100ps

module key_click_event_detector_test;
	import kced_pkg::*;

	localparam int KEYS            = 2;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_TICKS    = 56;

	// One expected event of a scan tick
	typedef struct packed {
		logic key;
		ev_t  code;
		logic last;
	} key_event_t;

	// Keeps a copy of the per-key phase machines and the queue of events they raise
	class key_event_scoreboard;
		logic             mode;
		logic [REG_W-1:0] long_press;
		logic [REG_W-1:0] short_min;
		logic [REG_W-1:0] short_max;
		logic [REG_W-1:0] gap1_max;
		logic [REG_W-1:0] gap2_max;
		logic [REG_W-1:0] hold2_max;
		logic [REG_W-1:0] hold3_max;
		phase_t           key_state [KEYS];
		logic [15:0]      ticks [KEYS];
		ev_t              last_ev [KEYS];
		key_event_t       awaited_events [$];
		int               errors;

		function new();
			mode = 1'b0;
			long_press = 16'd100;
			short_min = 16'd2;
			short_max = 16'd100;
			gap1_max = 16'd30;
			gap2_max = 16'd30;
			hold2_max = 16'd30;
			hold3_max = 16'd30;
			errors = 0;
			for (int k = 0; k < KEYS; k++) begin
				key_state[k] = PH_IDLE;
				ticks[k] = '0;
				last_ev[k] = EV_NONE;
			end
		endfunction

		function void set_reg(cfg_idx_t idx, logic [REG_W-1:0] v);
			case (idx)
				REG_MODE:        mode = v[0];
				REG_LONG_PRESS:  long_press = v;
				REG_SHORT_MIN:   short_min = v;
				REG_SHORT_MAX:   short_max = v;
				REG_FIRST_GAP:   gap1_max = v;
				REG_SECOND_GAP:  gap2_max = v;
				REG_SECOND_HOLD: hold2_max = v;
				REG_THIRD_HOLD:  hold3_max = v;
				default: ;
			endcase
		endfunction

		function logic [15:0] sat_inc(logic [15:0] t);
			return (t == 16'hFFFF) ? t : t + 16'd1;
		endfunction

		function void enter_phase(int k, phase_t p);
			key_state[k] = p;
			ticks[k] = '0;
		endfunction

		// Advance one key by one scan tick; return the event it raises
		function ev_t advance_key(int k, logic down);
			ev_t         ev;
			logic [15:0] t;
			logic        first;
			ev = last_ev[k];
			t = ticks[k];
			first = (key_state[k] == PH_GAP1 || key_state[k] == PH_PRESS2);
			case (key_state[k]) inside
				PH_IDLE: begin
					ev = EV_NONE;
					if (down)
						enter_phase(k, PH_PRESS1);
				end
				PH_PRESS1: begin
					if (down) begin
						t = sat_inc(t);
						ticks[k] = t;
						if (t == 16'd1)
							ev = EV_S_PRES;
						else if (t >= long_press)
							ev = (ev == EV_L_PRES || ev == EV_L_REPEAT) ? EV_L_REPEAT : EV_L_PRES;
						else
							ev = EV_NONE;
					end else if (!mode) begin
						if (t >= short_min && t < short_max)
							ev = EV_S_REL;
						else if (t >= long_press)
							ev = EV_L_REL;
						else
							ev = EV_NONE;
						enter_phase(k, PH_IDLE);
					end else if (t >= long_press) begin
						ev = EV_L_REL;
						enter_phase(k, PH_IDLE);
					end else begin
						ev = EV_NONE;
						enter_phase(k, PH_GAP1);
					end
				end
				PH_GAP1, PH_GAP2: begin
					if (down) begin
						enter_phase(k, first ? PH_PRESS2 : PH_PRESS3);
					end else begin
						t = sat_inc(t);
						ticks[k] = t;
						if (t > (first ? gap1_max : gap2_max)) begin
							ev = first ? EV_S_REL : EV_D_CLICK;
							enter_phase(k, PH_IDLE);
						end
					end
				end
				PH_PRESS2, PH_PRESS3: begin
					if (down) begin
						t = sat_inc(t);
						ticks[k] = t;
						if (t > (first ? hold2_max : hold3_max))
							enter_phase(k, PH_EXCEPT);
					end else begin
						enter_phase(k, first ? PH_GAP2 : PH_TRIPLE);
					end
				end
				PH_TRIPLE: begin
					ev = EV_T_CLICK;
					enter_phase(k, PH_IDLE);
				end
				default: begin
					ev = EV_NONE;
					if (!down)
						enter_phase(k, PH_IDLE);
				end
			endcase
			last_ev[k] = ev;
			return ev;
		endfunction

		// Note an accepted scan tick: queue its events in key order, mark the last
		function void note_tick(logic [PRESS_W-1:0] mask);
			key_event_t e;
			ev_t        ev;
			int         n;
			n = 0;
			for (int k = 0; k < KEYS; k++) begin
				ev = advance_key(k, mask[k]);
				if (ev != EV_NONE) begin
					e.key = k[0];
					e.code = ev;
					e.last = 1'b0;
					awaited_events.push_back(e);
					n++;
				end
			end
			if (n > 0)
				awaited_events[awaited_events.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare an accepted event with the oldest one awaited
		task check_event(logic key, logic [2:0] code, logic last);
			key_event_t e;
			if (awaited_events.size() == 0) begin
				report($sformatf("unexpected event key %0d code %0d", key, code));
			end else begin
				e = awaited_events.pop_front();
				if (key !== e.key)
					report($sformatf("key_id %0d, expected %0d", key, e.key));
				if (code !== e.code)
					report($sformatf("event_code %0d, expected %0d", code, e.code));
				if (last !== e.last)
					report($sformatf("last_event %0d, expected %0d", last, e.last));
			end
		endtask

		function int pending();
			return awaited_events.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PRESS_W-1:0]   pressed_mask = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 key_id;
	logic [2:0]           event_code;
	logic                 last_event;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	key_event_scoreboard sb;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int run_left [KEYS] = '{0, 0};
	logic level [KEYS] = '{1'b0, 1'b0};

	logic [PRESS_W-1:0] single_taps [9] = '{2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0};
	logic [PRESS_W-1:0] multi_taps [17] = '{2'd3, 2'd3, 2'd0, 2'd3, 2'd0, 2'd2, 2'd0, 2'd0,
		2'd3, 2'd3, 2'd0, 2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd0};

	key_click_event_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pressed_mask (pressed_mask),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_id       (key_id),
		.event_code   (event_code),
		.last_event   (last_event),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Watch both channels: check events first, then note the tick taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_event(key_id, event_code, last_event);
			if (in_valid && !in_stall)
				sb.note_tick(pressed_mask);
		end
	end

	// Drive the result stall: long hold-off on request, else random
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("key_click_event_detector_test NOT OK");
		$finish;
	end

	function automatic cfg_t make_cfg(logic m, logic [REG_W-1:0] lp, logic [REG_W-1:0] smin,
		logic [REG_W-1:0] smax, logic [REG_W-1:0] g1, logic [REG_W-1:0] g2,
		logic [REG_W-1:0] h2, logic [REG_W-1:0] h3);
		cfg_t c;
		c.multi_click_mode = m;
		c.long_press_ticks = lp;
		c.short_min_ticks = smin;
		c.short_max_ticks = smax;
		c.first_gap_ticks = g1;
		c.second_gap_ticks = g2;
		c.second_hold_max_ticks = h2;
		c.third_hold_max_ticks = h3;
		return c;
	endfunction

	// Write every register in index order; junk in the upper bits of the mode write
	task automatic apply_cfg(cfg_t c);
		logic [REG_W-1:0] vals [8];
		logic [14:0]      junk;
		junk = 15'($urandom);
		vals[REG_MODE] = {junk, c.multi_click_mode};
		vals[REG_LONG_PRESS] = c.long_press_ticks;
		vals[REG_SHORT_MIN] = c.short_min_ticks;
		vals[REG_SHORT_MAX] = c.short_max_ticks;
		vals[REG_FIRST_GAP] = c.first_gap_ticks;
		vals[REG_SECOND_GAP] = c.second_gap_ticks;
		vals[REG_SECOND_HOLD] = c.second_hold_max_ticks;
		vals[REG_THIRD_HOLD] = c.third_hold_max_ticks;
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			sb.set_reg(cfg_idx_t'(i), vals[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one scan tick after a random gap; hold it until taken
	task automatic send_tick(logic [PRESS_W-1:0] mask);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pressed_mask <= mask;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid, wait for every awaited event, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Pick a run length near the thresholds now in force
	function automatic int pick_run(logic pressed);
		int sel;
		int lim;
		int lp;
		sel = $urandom_range(9);
		if (pressed) begin
			lim = ((sb.hold2_max > sb.hold3_max) ? sb.hold2_max : sb.hold3_max) + 2;
			lp = (sb.long_press > 36) ? 36 : sb.long_press;
			if (lim > 40)
				lim = 40;
			if (sel < 6)
				return $urandom_range(1, lim);
			if (sel < 9)
				return (lp < 2) ? $urandom_range(1, 4) : $urandom_range(lp - 1, lp + 3);
			return $urandom_range(1, 40);
		end
		lim = ((sb.gap1_max > sb.gap2_max) ? sb.gap1_max : sb.gap2_max) + 3;
		if (lim > 40)
			lim = 40;
		if (sel < 8)
			return $urandom_range(1, lim);
		return $urandom_range(1, 40);
	endfunction

	// Mostly press/release runs per key, with some fully random masks mixed in
	task automatic random_ticks(int n);
		logic [PRESS_W-1:0] mask;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				mask = PRESS_W'($urandom_range(3));
			end else begin
				for (int k = 0; k < KEYS; k++) begin
					if (run_left[k] == 0) begin
						level[k] = ~level[k];
						run_left[k] = pick_run(level[k]);
					end
					mask[k] = level[k];
					run_left[k]--;
				end
			end
			send_tick(mask);
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single mode, short and long presses, both keys at once
		tx_idle_pct <= 21;
		rx_idle_pct <= 46;
		apply_cfg(make_cfg(1'b0, 16'd4, 16'd1, 16'd4, 16'd2, 16'd2, 16'd2, 16'd2));
		foreach (single_taps[i])
			send_tick(single_taps[i]);
		drain();

		// Directed: double, triple, exception; leave key 1 in its first gap
		apply_cfg(make_cfg(1'b1, 16'd4, 16'd1, 16'd4, 16'd2, 16'd2, 16'd2, 16'd2));
		foreach (multi_taps[i])
			send_tick(multi_taps[i]);
		drain();

		// Random phases over several settings and idling patterns
		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				tx_idle_pct <= 21;
				rx_idle_pct <= 46;
			end else if (p < 4) begin
				tx_idle_pct <= 46;
				rx_idle_pct <= 21;
			end else begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			case (p)
				0: apply_cfg(make_cfg(1'b0, 16'd5, 16'd2, 16'd5, 16'd3, 16'd3, 16'd3, 16'd3));
				1: apply_cfg(make_cfg(1'b1, 16'd6, 16'd2, 16'd5, 16'd3, 16'd2, 16'd3, 16'd2));
				2: apply_cfg(make_cfg(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
					16'd0, 16'hFFFF));
				3: apply_cfg(make_cfg(1'b0, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0,
					16'hFFFF, 16'd0));
				4: apply_cfg(make_cfg(1'b0, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1));
				default: apply_cfg(make_cfg(1'($urandom_range(1)), 16'($urandom_range(10)),
					16'($urandom_range(4)), 16'($urandom_range(12)), 16'($urandom_range(5)),
					16'($urandom_range(5)), 16'($urandom_range(5)), 16'($urandom_range(5))));
			endcase
			// Hold off the receiver while ticks keep coming
			if (p == 4)
				hold_requests <= hold_requests + 1;
			random_ticks(RANDOM_TICKS);
			// Release both keys long enough to bring them back to idle
			if (p == 5)
				repeat (12) send_tick(2'd0);
			drain();
		end

		if (sb.errors == 0)
			$display("key_click_event_detector_test OK");
		else
			$display("key_click_event_detector_test NOT OK");
		$finish;
	end

endmodule

// ===== key_click_event_detector.f =====
+incdir+src
src/kced_pkg.sv
src/kced_lane.sv
src/kced_merge.sv
src/key_click_event_detector.sv
bench/key_click_event_detector_test.sv
